// File: design/handoff_sequence_logger_unit_assert.svh
// Assertion macros shared by the handoff sequence logger modules.
`ifndef HANDOFF_SEQUENCE_LOGGER_UNIT_ASSERT_SVH
`define HANDOFF_SEQUENCE_LOGGER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HSL_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
// Next-cycle implication, disabled during reset.
`define HSL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
// A condition that must never hold.
`define HSL_ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("forbidden condition seen");
`else
`define HSL_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define HSL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`define HSL_ASSERT_NEVER(lbl, clk_i, rstn_i, cond)
`endif
`endif

// File: design/hslog_pkg.sv
// Types, constants and helper functions of the handoff sequence logger.
package hslog_pkg;

	localparam int ADDR_W       = 14;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 24;
	localparam int TMO_W        = 16;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int RECORD_BYTES = 16;
	localparam int REC_IDX_W    = $clog2(RECORD_BYTES);
	localparam int LOG_SLOTS    = 1023;
	localparam int Q_DEPTH      = 2;
	localparam int BEAT_W       = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TMO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TMO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd3;

	localparam logic [TMO_W-1:0] SHORT_TMO_RESET = 16'd2000;
	localparam logic [TMO_W-1:0] LONG_TMO_RESET  = 16'd60000;
	localparam logic [CNT_W-1:0] TOTAL_RESET     = 24'd3;
	localparam logic [CNT_W-1:0] CNT_MAX         = 24'hFF_FFFF;

	// Header and slot addresses.
	localparam logic [ADDR_W-1:0] ADDR_TOT_HI = 14'h0002;
	localparam logic [ADDR_W-1:0] ADDR_TOT_MI = 14'h0003;
	localparam logic [ADDR_W-1:0] ADDR_TOT_LO = 14'h0004;
	localparam logic [ADDR_W-1:0] ADDR_RUN_HI = 14'h000A;
	localparam logic [ADDR_W-1:0] ADDR_RUN_MI = 14'h000B;
	localparam logic [ADDR_W-1:0] ADDR_RUN_LO = 14'h000C;
	localparam logic [ADDR_W-1:0] ADDR_SLOT0  = 14'h000A;

	// Beat numbers within one log burst.
	localparam logic [BEAT_W-1:0] BEAT_TOT_HI = 5'd16;
	localparam logic [BEAT_W-1:0] BEAT_TOT_MI = 5'd17;
	localparam logic [BEAT_W-1:0] BEAT_TOT_LO = 5'd18;
	localparam logic [BEAT_W-1:0] BEAT_RUN_HI = 5'd19;
	localparam logic [BEAT_W-1:0] BEAT_RUN_MI = 5'd20;
	localparam logic [BEAT_W-1:0] BEAT_RUN_LO = 5'd21;
	localparam logic [BEAT_W-1:0] BEAT_LAST   = BEAT_RUN_LO;

	// Pass codes run upwards from the first coded byte, fail codes from the first failable one.
	localparam logic [BYTE_W-1:0]    CODE_PASS_FIRST = 8'hA1;
	localparam logic [BYTE_W-1:0]    CODE_FAIL_FIRST = 8'hF3;
	localparam logic [REC_IDX_W-1:0] PASS_FIRST_BYTE = 4'd2;
	localparam logic [REC_IDX_W-1:0] FAIL_FIRST_BYTE = 4'd4;

	typedef enum logic [3:0] {
		PH_WAIT_VALID     = 4'd1,
		PH_WAIT_REQ       = 4'd2,
		PH_WAIT_TRREQ     = 4'd3,
		PH_WAIT_READY     = 4'd4,
		PH_WAIT_BUSY      = 4'd5,
		PH_WAIT_REQ_OFF   = 4'd6,
		PH_WAIT_DONE      = 4'd7,
		PH_WAIT_READY_OFF = 4'd8,
		PH_WAIT_COMPT_OFF = 4'd9,
		PH_LOG            = 4'd10
	} phase_t;

	typedef logic [RECORD_BYTES-1:0][BYTE_W-1:0] record_t;

	// One pending log burst.
	typedef struct packed {
		record_t           rec;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  run;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [BYTE_W-1:0] pass_code(input logic [REC_IDX_W-1:0] idx);
		pass_code = CODE_PASS_FIRST + BYTE_W'(idx) - BYTE_W'(PASS_FIRST_BYTE);
	endfunction

	function automatic logic [BYTE_W-1:0] fail_code(input logic [REC_IDX_W-1:0] idx);
		fail_code = CODE_FAIL_FIRST + BYTE_W'(idx) - BYTE_W'(FAIL_FIRST_BYTE);
	endfunction

	function automatic logic [CNT_W-1:0] bump_cnt(input logic [CNT_W-1:0] v);
		bump_cnt = (v == CNT_MAX) ? CNT_W'(1) : v + CNT_W'(1);
	endfunction

endpackage

// File: design/hslog_front.sv
// Front part: configuration, phase tracking, timeout and record building.
`include "handoff_sequence_logger_unit_assert.svh"
module hslog_front #(
	parameter int LOG_SLOTS = hslog_pkg::LOG_SLOTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hslog_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hslog_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic                                 valid_n,
	input  logic                                 cs0_n,
	input  logic                                 cs1_n,
	input  logic                                 tr_req_n,
	input  logic                                 busy_n,
	input  logic                                 compt_n,
	input  logic                                 l_req_n,
	input  logic                                 u_req_n,
	input  logic                                 ready_n,
	input  hslog_pkg::q_stat_t                   q_stat,
	output logic                                 push,
	output hslog_pkg::job_t                      push_job
);

	localparam int SLOT_W = $clog2(LOG_SLOTS);

	logic                              en_q;
	logic [hslog_pkg::TMO_W-1:0]       short_q, long_q, tmo_q, tmo_d, tmo_dec;
	logic [hslog_pkg::CNT_W-1:0]       total_q, run_q, total_nx, run_nx;
	logic [SLOT_W-1:0]                 slot_q, slot_nx;
	hslog_pkg::phase_t                 phase_q, phase_d;
	hslog_pkg::record_t                rec_q, rec_d;
	logic                              accept, work, log_go, expired;
	logic [hslog_pkg::ADDR_W-1:0]      base;

	assign in_stall = en_q && (phase_q == hslog_pkg::PH_LOG) && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign work     = accept && en_q;

	assign tmo_dec = (kind && (tmo_q != '0)) ? tmo_q - 1'b1 : tmo_q;
	assign expired = (tmo_dec == '0);

	always_comb begin
		total_nx = hslog_pkg::bump_cnt(total_q);
		run_nx   = hslog_pkg::bump_cnt(run_q);
		if (run_q == hslog_pkg::CNT_MAX) begin
			slot_nx = SLOT_W'(1);
		end else if (slot_q == SLOT_W'(LOG_SLOTS - 1)) begin
			slot_nx = '0;
		end else begin
			slot_nx = slot_q + 1'b1;
		end
		base = hslog_pkg::ADDR_W'(slot_nx) << hslog_pkg::REC_IDX_W;
		if (base == '0) begin
			base = hslog_pkg::ADDR_SLOT0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		tmo_d   = tmo_q;
		rec_d   = rec_q;
		log_go  = 1'b0;
		if (work) begin
			tmo_d = tmo_dec;
			case (phase_q)
				hslog_pkg::PH_WAIT_VALID: begin
					if ((!cs0_n || !cs1_n) && !valid_n) begin
						rec_d[2] = hslog_pkg::pass_code(4'd2);
						rec_d[3] = hslog_pkg::pass_code(4'd3);
						tmo_d    = short_q;
						phase_d  = hslog_pkg::PH_WAIT_REQ;
					end
				end
				hslog_pkg::PH_WAIT_REQ: begin
					if (expired) begin
						rec_d[4] = hslog_pkg::fail_code(4'd4);
						phase_d  = hslog_pkg::PH_LOG;
					end else if (!l_req_n || !u_req_n) begin
						rec_d[4] = hslog_pkg::pass_code(4'd4);
						tmo_d    = short_q;
						phase_d  = hslog_pkg::PH_WAIT_TRREQ;
					end
				end
				hslog_pkg::PH_WAIT_TRREQ: begin
					if (expired) begin
						rec_d[5] = hslog_pkg::fail_code(4'd5);
						phase_d  = hslog_pkg::PH_LOG;
					end else if (!tr_req_n) begin
						rec_d[5] = hslog_pkg::pass_code(4'd5);
						tmo_d    = short_q;
						phase_d  = hslog_pkg::PH_WAIT_READY;
					end
				end
				hslog_pkg::PH_WAIT_READY: begin
					if (expired) begin
						rec_d[6] = hslog_pkg::fail_code(4'd6);
						phase_d  = hslog_pkg::PH_LOG;
					end else if (!ready_n) begin
						rec_d[6] = hslog_pkg::pass_code(4'd6);
						tmo_d    = short_q;
						phase_d  = hslog_pkg::PH_WAIT_BUSY;
					end
				end
				hslog_pkg::PH_WAIT_BUSY: begin
					if (expired) begin
						rec_d[7] = hslog_pkg::fail_code(4'd7);
						phase_d  = hslog_pkg::PH_LOG;
					end else if (!busy_n) begin
						rec_d[7] = hslog_pkg::pass_code(4'd7);
						tmo_d    = long_q;
						phase_d  = hslog_pkg::PH_WAIT_REQ_OFF;
					end
				end
				hslog_pkg::PH_WAIT_REQ_OFF: begin
					if (expired) begin
						rec_d[8] = hslog_pkg::fail_code(4'd8);
						phase_d  = hslog_pkg::PH_LOG;
					end else if (l_req_n && u_req_n) begin
						rec_d[8] = hslog_pkg::pass_code(4'd8);
						tmo_d    = long_q;
						phase_d  = hslog_pkg::PH_WAIT_DONE;
					end
				end
				hslog_pkg::PH_WAIT_DONE: begin
					if (expired) begin
						rec_d[9]  = hslog_pkg::fail_code(4'd9);
						rec_d[10] = hslog_pkg::fail_code(4'd10);
						rec_d[11] = hslog_pkg::fail_code(4'd11);
						phase_d   = hslog_pkg::PH_LOG;
					end else if (busy_n && tr_req_n && !compt_n) begin
						rec_d[9]  = hslog_pkg::pass_code(4'd9);
						rec_d[10] = hslog_pkg::pass_code(4'd10);
						rec_d[11] = hslog_pkg::pass_code(4'd11);
						tmo_d     = short_q;
						phase_d   = hslog_pkg::PH_WAIT_READY_OFF;
					end
				end
				hslog_pkg::PH_WAIT_READY_OFF: begin
					if (expired) begin
						rec_d[12] = hslog_pkg::fail_code(4'd12);
						phase_d   = hslog_pkg::PH_LOG;
					end else if (ready_n) begin
						rec_d[12] = hslog_pkg::pass_code(4'd12);
						tmo_d     = short_q;
						phase_d   = hslog_pkg::PH_WAIT_COMPT_OFF;
					end
				end
				hslog_pkg::PH_WAIT_COMPT_OFF: begin
					if (expired) begin
						rec_d[13] = hslog_pkg::fail_code(4'd13);
						rec_d[14] = hslog_pkg::fail_code(4'd14);
						rec_d[15] = hslog_pkg::fail_code(4'd15);
						phase_d   = hslog_pkg::PH_LOG;
					end else if (compt_n) begin
						rec_d[13] = hslog_pkg::pass_code(4'd13);
						rec_d[14] = hslog_pkg::pass_code(4'd14);
						rec_d[15] = hslog_pkg::pass_code(4'd15);
						phase_d   = hslog_pkg::PH_LOG;
					end
				end
				hslog_pkg::PH_LOG: begin
					log_go  = 1'b1;
					rec_d   = '0;
					phase_d = hslog_pkg::PH_WAIT_VALID;
				end
				default: begin
					phase_d = hslog_pkg::PH_WAIT_VALID;
				end
			endcase
		end
	end

	assign push           = log_go;
	assign push_job.rec   = rec_q;
	assign push_job.base  = base;
	assign push_job.total = total_nx;
	assign push_job.run   = run_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			short_q <= hslog_pkg::SHORT_TMO_RESET;
			long_q  <= hslog_pkg::LONG_TMO_RESET;
			total_q <= hslog_pkg::TOTAL_RESET;
			run_q   <= '0;
			slot_q  <= '0;
			phase_q <= hslog_pkg::PH_WAIT_VALID;
			tmo_q   <= '0;
			rec_q   <= '0;
		end else begin
			phase_q <= phase_d;
			tmo_q   <= tmo_d;
			rec_q   <= rec_d;
			if (log_go) begin
				total_q <= total_nx;
				run_q   <= run_nx;
				slot_q  <= slot_nx;
			end
			if (cfg_we) begin
				case (cfg_index)
					hslog_pkg::CFG_ENABLE:    en_q    <= cfg_data[0];
					hslog_pkg::CFG_SHORT_TMO: short_q <= cfg_data[hslog_pkg::TMO_W-1:0];
					hslog_pkg::CFG_LONG_TMO:  long_q  <= cfg_data[hslog_pkg::TMO_W-1:0];
					hslog_pkg::CFG_TOTAL:     total_q <= cfg_data[hslog_pkg::CNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	`HSL_ASSERT_NEXT(a_log_returns_idle, clk, arst_n, log_go, (phase_q == hslog_pkg::PH_WAIT_VALID) && (rec_q == '0))

endmodule

// File: design/hslog_queue.sv
// Short queue of pending log bursts between front and back.
`include "handoff_sequence_logger_unit_assert.svh"
module hslog_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hslog_pkg::job_t    push_job,
	input  logic               pop,
	output hslog_pkg::job_t    head,
	output hslog_pkg::q_stat_t q_stat
);

	localparam int PTR_W = (hslog_pkg::Q_DEPTH > 1) ? $clog2(hslog_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(hslog_pkg::Q_DEPTH + 1);

	hslog_pkg::job_t   slot_q [hslog_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == CNT_W'(hslog_pkg::Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(hslog_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(hslog_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`HSL_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && q_stat.full)
	`HSL_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && q_stat.empty)

endmodule

// File: design/hslog_back.sv
// Back part: turns each queued burst into 22 byte-write beats.
`include "handoff_sequence_logger_unit_assert.svh"
module hslog_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hslog_pkg::job_t                  head,
	input  hslog_pkg::q_stat_t               q_stat,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [hslog_pkg::ADDR_W-1:0]     write_address,
	output logic [hslog_pkg::BYTE_W-1:0]     write_byte,
	output logic                             last_write
);

	logic [hslog_pkg::BEAT_W-1:0]  beat_q;
	logic                          out_valid_q, last_q, load, last_d;
	logic [hslog_pkg::ADDR_W-1:0]  addr_q, addr_d;
	logic [hslog_pkg::BYTE_W-1:0]  byte_q, byte_d;

	assign load = !q_stat.empty && (!out_valid_q || !out_stall);
	assign pop  = load && (beat_q == hslog_pkg::BEAT_LAST);

	always_comb begin
		addr_d = head.base + hslog_pkg::ADDR_W'(beat_q);
		byte_d = head.rec[beat_q[hslog_pkg::REC_IDX_W-1:0]];
		last_d = 1'b0;
		case (beat_q)
			hslog_pkg::BEAT_TOT_HI: begin
				addr_d = hslog_pkg::ADDR_TOT_HI;
				byte_d = head.total[23:16];
			end
			hslog_pkg::BEAT_TOT_MI: begin
				addr_d = hslog_pkg::ADDR_TOT_MI;
				byte_d = head.total[15:8];
			end
			hslog_pkg::BEAT_TOT_LO: begin
				addr_d = hslog_pkg::ADDR_TOT_LO;
				byte_d = head.total[7:0];
			end
			hslog_pkg::BEAT_RUN_HI: begin
				addr_d = hslog_pkg::ADDR_RUN_HI;
				byte_d = head.run[23:16];
			end
			hslog_pkg::BEAT_RUN_MI: begin
				addr_d = hslog_pkg::ADDR_RUN_MI;
				byte_d = head.run[15:8];
			end
			hslog_pkg::BEAT_RUN_LO: begin
				addr_d = hslog_pkg::ADDR_RUN_LO;
				byte_d = head.run[7:0];
				last_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= addr_d;
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				beat_q      <= pop ? '0 : beat_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = addr_q;
	assign write_byte    = byte_q;
	assign last_write    = last_q;

	`HSL_ASSERT_IMP(a_pop_at_last_beat, clk, arst_n, pop, beat_q == hslog_pkg::BEAT_LAST)
	`HSL_ASSERT_IMP(a_last_is_run_lo, clk, arst_n, out_valid_q && last_q, addr_q == hslog_pkg::ADDR_RUN_LO)

endmodule

// File: design/handoff_sequence_logger_unit.sv
// Top level of the handoff sequence logger: front, burst queue and write back end.
// The logger watches the active-low pins of a parallel load-port handoff and takes one
// sample beat every clock cycle unless the input stalls. Each beat feeds a phase tracker in
// the front part. A beat with kind set counts the current phase timeout down by one
// millisecond. Each wait phase writes pass codes into a 16-byte record, and each one after
// the first writes fail codes on a timeout. When the sequence completes or times out, the
// following beat closes the record. It also bumps the total and run counts, which wrap to
// one after all ones, and hands the record with its slot address and both counts to a
// two-entry burst queue. The back part drains the queue at one write beat per cycle while
// out_stall is low: sixteen record bytes at the slot address, then six header bytes (total
// count at 0x0002..0x0004 and run count at 0x000A..0x000C, high byte first). The last of
// these carries last_write. The slot address is the run count modulo LOG_SLOTS times
// sixteen, kept by a running slot counter, and slot zero lands at 0x000A. A burst occupies
// the output for 22 write beats. The input stalls only when a record waits to close while
// both queue entries hold bursts not yet fully written. Configuration registers are written
// with cfg_we, cfg_index and cfg_data while the logger is idle. Clearing CFG_ENABLE
// freezes the tracker, but sample beats are still taken and produce no writes.
module handoff_sequence_logger_unit #(
	parameter int LOG_SLOTS = hslog_pkg::LOG_SLOTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hslog_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hslog_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic                                 valid_n,
	input  logic                                 cs0_n,
	input  logic                                 cs1_n,
	input  logic                                 tr_req_n,
	input  logic                                 busy_n,
	input  logic                                 compt_n,
	input  logic                                 l_req_n,
	input  logic                                 u_req_n,
	input  logic                                 ready_n,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [hslog_pkg::ADDR_W-1:0]         write_address,
	output logic [hslog_pkg::BYTE_W-1:0]         write_byte,
	output logic                                 last_write
);

	// Burst handoff between the phase tracker and the write sequencer.
	hslog_pkg::q_stat_t q_stat;
	hslog_pkg::job_t    push_job, head;
	logic               push, pop;

	// The front part follows the handshake phases and closes records into bursts.
	hslog_front #(
		.LOG_SLOTS (LOG_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.valid_n   (valid_n),
		.cs0_n     (cs0_n),
		.cs1_n     (cs1_n),
		.tr_req_n  (tr_req_n),
		.busy_n    (busy_n),
		.compt_n   (compt_n),
		.l_req_n   (l_req_n),
		.u_req_n   (u_req_n),
		.ready_n   (ready_n),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// The queue lets the tracker carry on sampling while a burst is written out.
	hslog_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// The back part sends one registered write beat per cycle while out_stall is low.
	hslog_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_address (write_address),
		.write_byte    (write_byte),
		.last_write    (last_write)
	);

endmodule
